@@ rtl/ttm_pkg.sv @@
// ---------------------------------------------------------------------------
// ttm_pkg: shared types and constants of the tick timer manager
// Holds the slot count, operation and result codes, the controller states
// and the command/status structs between the controller and the datapath.
// ---------------------------------------------------------------------------
package ttm_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	localparam logic [15:0] TPS_RESET = 16'd100;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_STOP  = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_EXPIRED  = 2'd0,
		KIND_ACCEPTED = 2'd1,
		KIND_REJECTED = 2'd2,
		KIND_QUERY    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_EXEC,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic capture;
		logic calc;
		logic exec;
		logic scan_step;
		logic flush;
	} ttm_cmd_t;

	typedef struct packed {
		func_t func;
		logic  due;
		logic  pend_valid;
		logic  out_free;
		logic  scan_last;
	} ttm_stat_t;

	// Ticks left from a wraparound difference; negative reads as zero.
	function automatic logic [30:0] clamp_left(input logic [31:0] d);
		clamp_left = d[31] ? 31'd0 : d[30:0];
	endfunction

endpackage

@@ rtl/ttm_ctrl.sv @@
// ---------------------------------------------------------------------------
// ttm_ctrl: sequencing controller of the tick timer manager
// Captures one operation at a time, steps the slot scan on a tick and
// issues the result pushes to the datapath.
// ---------------------------------------------------------------------------
module ttm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ttm_pkg::ttm_stat_t stat,
	output ttm_pkg::ttm_cmd_t  cmd
);
	import ttm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   scan_stall;

	// The held expiry can move out only when the output register frees up.
	assign scan_stall = stat.due && stat.pend_valid && !stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CALC;
			end
			ST_CALC: begin
				state_d = (stat.func == FUNC_TICK) ? ST_SCAN : ST_EXEC;
			end
			ST_EXEC: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (!scan_stall && stat.scan_last) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!stat.pend_valid || stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
			end
			ST_EXEC: begin
				cmd.exec = stat.out_free;
			end
			ST_SCAN: begin
				cmd.scan_step = !scan_stall;
			end
			ST_FLUSH: begin
				cmd.flush = stat.pend_valid && stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !stat.pend_valid)
		else $error("held expiry left over in idle");

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (state_q == ST_IDLE))
		else $error("flush did not end the tick");

endmodule

@@ rtl/ttm_dp.sv @@
// ---------------------------------------------------------------------------
// ttm_dp: datapath of the tick timer manager
// Tick counter, slot register file, seconds scaling, expiry compare,
// held expiry stage and the output register.
// ---------------------------------------------------------------------------
module ttm_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ttm_pkg::ttm_cmd_t  cmd,
	output ttm_pkg::ttm_stat_t stat,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic [1:0]         func,
	input  logic [3:0]         slot,
	input  logic [31:0]        period,
	input  logic               in_seconds,
	input  logic               repeat_req,
	input  logic [31:0]        tag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [3:0]         slot_out,
	output logic [31:0]        tag_out,
	output logic               running,
	output logic [30:0]        remaining,
	output logic [31:0]        now,
	output logic               last
);
	import ttm_pkg::*;

	// configuration and counter
	logic [15:0] tps_q;
	logic [31:0] now_q;

	// captured operation
	func_t       func_q;
	logic [3:0]  slot_q;
	logic [31:0] period_q;
	logic        in_sec_q;
	logic        rep_q;
	logic [31:0] tag_q;
	logic [31:0] t_q;
	logic [SLOT_AW-1:0] idx_q;

	// slot register file
	logic [31:0]          exp_q  [NUM_SLOTS];
	logic [31:0]          rel_q  [NUM_SLOTS];
	logic [31:0]          stag_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] srep_q;
	logic [NUM_SLOTS-1:0] armed_q;

	// held expiry result
	logic        pend_valid_q;
	logic [3:0]  pend_slot_q;
	logic [31:0] pend_tag_q;
	logic        pend_run_q;
	logic [30:0] pend_rem_q;

	// output register
	logic        out_valid_q;
	kind_t       kind_q;
	logic [3:0]  slot_out_q;
	logic [31:0] tag_out_q;
	logic        running_q;
	logic [30:0] remaining_q;
	logic [31:0] now_out_q;
	logic        last_q;

	logic [SLOT_AW-1:0] rd_addr;
	logic        slot_ok;
	logic        rd_armed;
	logic        rd_rep;
	logic [31:0] rd_exp;
	logic [31:0] rd_rel;
	logic [31:0] rd_tag;
	logic [31:0] diff;
	logic [30:0] left;
	logic        due;
	logic        expire;
	logic        out_free;
	logic        push;
	logic [31:0] prod;

	kind_t       r_kind;
	logic        r_run;
	logic [30:0] r_rem;
	logic        do_arm;
	logic        do_disarm;

	assign rd_addr  = (func_q == FUNC_TICK) ? idx_q : SLOT_AW'(slot_q);
	assign slot_ok  = (32'(slot_q) < 32'(NUM_SLOTS));
	assign rd_armed = armed_q[rd_addr];
	assign rd_rep   = srep_q[rd_addr];
	assign rd_exp   = exp_q[rd_addr];
	assign rd_rel   = rel_q[rd_addr];
	assign rd_tag   = stag_q[rd_addr];
	assign diff     = rd_exp - now_q;
	assign left     = rd_armed ? clamp_left(diff) : 31'd0;
	assign due      = rd_armed && ((diff == 32'd0) || diff[31]);
	assign expire   = cmd.scan_step && due;
	assign out_free = !out_valid_q || out_ready;
	assign push     = cmd.exec || cmd.flush || (expire && pend_valid_q);
	// seconds scaling wraps at 32 bits
	assign prod     = period_q * 32'(tps_q);

	assign stat.func       = func_q;
	assign stat.due        = due;
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = out_free;
	assign stat.scan_last  = (idx_q == SLOT_AW'(NUM_SLOTS - 1));

	// single-result operations
	always_comb begin
		r_kind    = KIND_QUERY;
		r_run     = 1'b0;
		r_rem     = 31'd0;
		do_arm    = 1'b0;
		do_disarm = 1'b0;
		case (func_q)
			FUNC_START: begin
				if (!slot_ok || rd_armed) begin
					r_kind = KIND_REJECTED;
					r_run  = slot_ok && rd_armed;
					r_rem  = slot_ok ? left : 31'd0;
				end else begin
					r_kind = KIND_ACCEPTED;
					r_run  = 1'b1;
					r_rem  = clamp_left(t_q);
					do_arm = 1'b1;
				end
			end
			FUNC_STOP: begin
				if (!slot_ok) begin
					r_kind = KIND_REJECTED;
				end else begin
					r_kind    = KIND_ACCEPTED;
					do_disarm = 1'b1;
				end
			end
			FUNC_QUERY: begin
				r_kind = KIND_QUERY;
				r_run  = slot_ok && rd_armed;
				r_rem  = slot_ok ? left : 31'd0;
			end
			default: begin
				r_kind = KIND_EXPIRED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			now_q <= '0;
		end else begin
			if (cfg_we) tps_q <= cfg_wdata;
			if (cmd.capture && (func == FUNC_TICK)) now_q <= now_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= func_t'(func);
			slot_q   <= slot;
			period_q <= period;
			in_sec_q <= in_seconds;
			rep_q    <= repeat_req;
			tag_q    <= tag;
			idx_q    <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + SLOT_AW'(1);
		end
		if (cmd.calc) t_q <= in_sec_q ? prod : period_q;
	end

	// slot payload has no reset: read only while armed
	always_ff @(posedge clk) begin
		if (cmd.exec && do_arm) begin
			exp_q[rd_addr]  <= now_q + t_q;
			rel_q[rd_addr]  <= t_q;
			stag_q[rd_addr] <= tag_q;
			srep_q[rd_addr] <= rep_q;
		end else if (expire && rd_rep) begin
			exp_q[rd_addr] <= now_q + rd_rel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else begin
			if (cmd.exec && do_arm) begin
				armed_q[rd_addr] <= 1'b1;
			end else if (cmd.exec && do_disarm) begin
				armed_q[rd_addr] <= 1'b0;
			end else if (expire && !rd_rep) begin
				armed_q[rd_addr] <= 1'b0;
			end
		end
	end

	// hold each expiry until the next one shows whether it is the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (expire) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.flush) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (expire) begin
			pend_slot_q <= 4'(idx_q);
			pend_tag_q  <= rd_tag;
			pend_run_q  <= rd_rep;
			pend_rem_q  <= rd_rep ? clamp_left(rd_rel) : 31'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= push || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			kind_q      <= r_kind;
			slot_out_q  <= slot_q;
			tag_out_q   <= '0;
			running_q   <= r_run;
			remaining_q <= r_rem;
			now_out_q   <= now_q;
			last_q      <= 1'b1;
		end else if (push) begin
			kind_q      <= KIND_EXPIRED;
			slot_out_q  <= pend_slot_q;
			tag_out_q   <= pend_tag_q;
			running_q   <= pend_run_q;
			remaining_q <= pend_rem_q;
			now_out_q   <= now_q;
			last_q      <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign slot_out  = slot_out_q;
	assign tag_out   = tag_out_q;
	assign running   = running_q;
	assign remaining = remaining_q;
	assign now       = now_out_q;
	assign last      = last_q;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || out_ready))
		else $error("result pushed over a waiting result");

	a_tick_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.capture && (func == FUNC_TICK)) |=> (now_q == $past(now_q) + 32'd1))
		else $error("tick did not advance the counter");

endmodule

@@ rtl/tick_timer_manager_unit.sv @@
// ---------------------------------------------------------------------------
// tick_timer_manager_unit: bank of software-style timer slots
// Start, stop and query pass capture, calc and exec; exec waits for a free
// output register. A tick scans one slot per cycle through a single
// register-file port unless a held expiry waits on the output, then flushes.
// One operation is in flight at a time. Reset clears the tick counter and
// all armed flags and loads ticks_per_second with 100; no clearing pass.
// ---------------------------------------------------------------------------
module tick_timer_manager_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [3:0]  slot,
	input  logic [31:0] period,
	input  logic        in_seconds,
	input  logic        repeat_req,
	input  logic [31:0] tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  slot_out,
	output logic [31:0] tag_out,
	output logic        running,
	output logic [30:0] remaining,
	output logic [31:0] now,
	output logic        last
);
	import ttm_pkg::*;

	ttm_cmd_t  cmd;
	ttm_stat_t stat;

	ttm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ttm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.func       (func),
		.slot       (slot),
		.period     (period),
		.in_seconds (in_seconds),
		.repeat_req (repeat_req),
		.tag        (tag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.slot_out   (slot_out),
		.tag_out    (tag_out),
		.running    (running),
		.remaining  (remaining),
		.now        (now),
		.last       (last)
	);

endmodule

@@ test/ttm_checker.sv @@
// ---------------------------------------------------------------------------
// ttm_checker: result checker for the tick timer manager
// Watches the input, output and config ports, keeps its own copy of the
// tick counter and the slot bank, works out the results of every input
// transfer and compares each output transfer with the oldest one waiting.
// ---------------------------------------------------------------------------
module ttm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic [3:0]  slot,
	input  logic [31:0] period,
	input  logic        in_seconds,
	input  logic        repeat_req,
	input  logic [31:0] tag,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  slot_out,
	input  logic [31:0] tag_out,
	input  logic        running,
	input  logic [30:0] remaining,
	input  logic [31:0] now,
	input  logic        last,
	output int          fail_count,
	output int          events_due
);
	import ttm_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  slot;
		logic [31:0] tag;
		logic        running;
		logic [30:0] remaining;
		logic [31:0] now;
		logic        last;
	} timer_event_t;

	logic [15:0] tps;
	logic [31:0] tick_cnt;
	logic [31:0] expiry [NUM_SLOTS];
	logic [31:0] reload [NUM_SLOTS];
	logic [31:0] stored_tag [NUM_SLOTS];
	logic        armed [NUM_SLOTS];
	logic        rep_mode [NUM_SLOTS];
	timer_event_t timer_events_q [$];

	function automatic logic [30:0] ticks_left(input int s);
		logic [31:0] d;
		if (!armed[s])
			return 31'd0;
		d = expiry[s] - tick_cnt;
		return d[31] ? 31'd0 : d[30:0];
	endfunction

	task automatic push_event(input kind_t k, input logic [3:0] s, input logic [31:0] t,
			input logic run, input logic [30:0] rem, input logic lst);
		timer_event_t ev;
		ev.kind = k;
		ev.slot = s;
		ev.tag = t;
		ev.running = run;
		ev.remaining = rem;
		ev.now = tick_cnt;
		ev.last = lst;
		timer_events_q.push_back(ev);
	endtask

	task automatic apply_item(input func_t f, input logic [3:0] s, input logic [31:0] p,
			input logic secs, input logic rep, input logic [31:0] t);
		int n;
		logic ok;
		logic [31:0] d;
		logic [31:0] ticks;
		timer_event_t ev;
		n = 0;
		ok = int'(s) < NUM_SLOTS;
		case (f)
			FUNC_TICK: begin
				tick_cnt = tick_cnt + 32'd1;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (armed[i]) begin
						d = expiry[i] - tick_cnt;
						if (d == 32'd0 || d[31]) begin
							if (rep_mode[i])
								expiry[i] = tick_cnt + reload[i];
							else
								armed[i] = 1'b0;
							push_event(KIND_EXPIRED, 4'(i), stored_tag[i], armed[i],
								ticks_left(i), 1'b0);
							n++;
						end
					end
				end
				// mark the final expiry of this tick
				if (n > 0) begin
					ev = timer_events_q.pop_back();
					ev.last = 1'b1;
					timer_events_q.push_back(ev);
				end
			end
			FUNC_START: begin
				if (!ok || armed[s]) begin
					push_event(KIND_REJECTED, s, 32'd0, ok ? armed[s] : 1'b0,
						ok ? ticks_left(s) : 31'd0, 1'b1);
				end else begin
					ticks = secs ? p * {16'd0, tps} : p;
					expiry[s] = tick_cnt + ticks;
					reload[s] = ticks;
					rep_mode[s] = rep;
					stored_tag[s] = t;
					armed[s] = 1'b1;
					push_event(KIND_ACCEPTED, s, 32'd0, 1'b1, ticks_left(s), 1'b1);
				end
			end
			FUNC_STOP: begin
				if (!ok) begin
					push_event(KIND_REJECTED, s, 32'd0, 1'b0, 31'd0, 1'b1);
				end else begin
					armed[s] = 1'b0;
					push_event(KIND_ACCEPTED, s, 32'd0, 1'b0, 31'd0, 1'b1);
				end
			end
			default: begin
				push_event(KIND_QUERY, s, 32'd0, ok ? armed[s] : 1'b0,
					ok ? ticks_left(s) : 31'd0, 1'b1);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_event_t want;
		timer_event_t got;
		if (!arst_n) begin
			tps = TPS_RESET;
			tick_cnt = 32'd0;
			for (int i = 0; i < NUM_SLOTS; i++)
				armed[i] = 1'b0;
			timer_events_q.delete();
			fail_count = 0;
			events_due = 0;
		end else begin
			// check the output side first: a result leaving on the edge of a new
			// input transfer belongs to an older input
			if (out_valid && out_ready) begin
				got.kind = kind_t'(kind);
				got.slot = slot_out;
				got.tag = tag_out;
				got.running = running;
				got.remaining = remaining;
				got.now = now;
				got.last = last;
				if (timer_events_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: kind=%0d slot=%0d tag=%h run=%0d rem=%0d now=%0d last=%0d",
							got.kind, got.slot, got.tag, got.running, got.remaining,
							got.now, got.last);
				end else begin
					want = timer_events_q.pop_front();
					if (got.kind !== want.kind || got.slot !== want.slot ||
							got.tag !== want.tag || got.running !== want.running ||
							got.remaining !== want.remaining || got.now !== want.now ||
							got.last !== want.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch expected: kind=%0d slot=%0d tag=%h run=%0d rem=%0d now=%0d last=%0d",
								want.kind, want.slot, want.tag, want.running, want.remaining,
								want.now, want.last);
							$display("         actual:   kind=%0d slot=%0d tag=%h run=%0d rem=%0d now=%0d last=%0d",
								got.kind, got.slot, got.tag, got.running, got.remaining,
								got.now, got.last);
						end
					end
				end
			end
			if (in_valid && in_ready)
				apply_item(func_t'(func), slot, period, in_seconds, repeat_req, tag);
			if (cfg_we)
				tps = cfg_wdata;
			events_due = timer_events_q.size();
		end
	end

endmodule

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb: testbench for tick_timer_manager_unit
// Drives directed and random start, stop, query and tick commands under
// several ticks_per_second settings, with random idling on both channels;
// the checker module predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
	import ttm_pkg::*;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = FUNC_TICK;
	logic [3:0]  slot = 4'd0;
	logic [31:0] period = 32'd0;
	logic        in_seconds = 1'b0;
	logic        repeat_req = 1'b0;
	logic [31:0] tag = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [3:0]  slot_out;
	logic [31:0] tag_out;
	logic        running;
	logic [30:0] remaining;
	logic [31:0] now;
	logic        last;
	int          fail_count;
	int          events_due;
	logic        steady = 1'b0;

	tick_timer_manager_unit dut (.*);

	ttm_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb failed");
		$finish;
	end

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= 17);

	task automatic send(input func_t f, input logic [3:0] s, input logic [31:0] p,
			input logic secs, input logic rep, input logic [31:0] t);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 17) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func <= f;
		slot <= s;
		period <= p;
		in_seconds <= secs;
		repeat_req <= rep;
		tag <= t;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// drain all results, then wait with the input idle
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (events_due != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_tps(input logic [15:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] tps_list [5];
		logic [31:0] p;
		logic        secs;
		int          n;
		int          r;
		int          pick;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at the reset scale of 100 ticks per second
		send(FUNC_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_STOP, 4'd3, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_START, 4'd0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
		send(FUNC_START, 4'd0, 32'd5, 1'b0, 1'b0, 32'h1234_5678);
		send(FUNC_START, 4'd15, 32'd2, 1'b1, 1'b1, 32'd0);
		send(FUNC_START, 4'd1, 32'd0, 1'b0, 1'b1, 32'hA5A5_5A5A);
		send(FUNC_START, 4'd2, 32'd1, 1'b0, 1'b1, 32'h0000_0001);
		send(FUNC_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_QUERY, 4'd15, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_QUERY, 4'd1, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_STOP, 4'd1, 32'd0, 1'b0, 1'b0, 32'd0);
		// expiry one tick in the past: remaining clamps to zero
		send(FUNC_START, 4'd5, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h8000_0000);
		send(FUNC_START, 4'd6, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h7FFF_FFFF);
		// seconds product wraps
		send(FUNC_START, 4'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_0000);
		send(FUNC_QUERY, 4'd5, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_QUERY, 4'd6, 32'd0, 1'b0, 1'b0, 32'd0);
		send(FUNC_QUERY, 4'd7, 32'd0, 1'b0, 1'b0, 32'd0);

		// zero scale: seconds become zero ticks
		write_tps(16'd0);
		send(FUNC_START, 4'd8, 32'd3, 1'b1, 1'b0, 32'h0F0F_F0F0);
		send(FUNC_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0);

		tps_list = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 300)), 16'd100,
			16'($urandom_range(1, 65535))};
		for (int ph = 0; ph < 5; ph++) begin
			write_tps(tps_list[ph]);
			steady = (ph == 2);
			n = 0;
			while (n < 70) begin
				if ((ph == 1 && n == 0) || $urandom_range(0, 149) == 0) begin
					// rearm every slot to expire together on the next tick
					r = $urandom_range(0, 1);
					for (int i = 0; i < NUM_SLOTS; i++) begin
						send(FUNC_STOP, 4'(i), 32'd0, 1'b0, 1'b0, 32'd0);
						send(FUNC_START, 4'(i), 32'd0, 1'b0, r[0], $urandom());
					end
					send(FUNC_TICK, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0);
					n += 2 * NUM_SLOTS + 1;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 45) begin
						send(FUNC_TICK, 4'($urandom()), $urandom(), 1'($urandom()),
							1'($urandom()), $urandom());
					end else if (r < 72) begin
						pick = $urandom_range(0, 9);
						secs = 1'b0;
						if (pick < 6) begin
							p = $urandom_range(0, 12);
						end else if (pick < 8) begin
							p = $urandom_range(0, 3);
							secs = 1'b1;
						end else if (pick == 8) begin
							p = $urandom();
							secs = 1'($urandom());
						end else begin
							p = $urandom_range(0, 40);
						end
						send(FUNC_START, 4'($urandom()), p, secs, 1'($urandom()),
							$urandom());
					end else if (r < 84) begin
						send(FUNC_STOP, 4'($urandom()), $urandom(), 1'($urandom()),
							1'($urandom()), $urandom());
					end else begin
						send(FUNC_QUERY, 4'($urandom()), $urandom(), 1'($urandom()),
							1'($urandom()), $urandom());
					end
					n++;
				end
			end
		end
		steady = 1'b0;

		settle();
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ttm_pkg.sv
rtl/ttm_ctrl.sv
rtl/ttm_dp.sv
rtl/tick_timer_manager_unit.sv
test/ttm_checker.sv
test/tb.sv
